/* rtl/catan_pkg.sv */
// shared types, constants and the arctangent table for the cordic atan2 unit
package catan_pkg;

  localparam int ITERS      = 16;
  localparam int ITER_W     = 4;
  localparam int WORD_W     = 34;
  localparam int Z_W        = 20;
  localparam int ANGLE_W    = 12;
  localparam int FRAC_SHIFT = 8;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [Z_W-1:0]    zacc_t;

  localparam word_t NORM_HIGH   = word_t'(1 << 20);
  localparam word_t NORM_LOW    = word_t'(1 << 18);
  localparam zacc_t FRAC_HALF   = zacc_t'((1 << FRAC_SHIFT) / 2);
  localparam logic [ANGLE_W-1:0] HALF_TURN = ANGLE_W'((1 << ANGLE_W) / 2);
  localparam logic [ITER_W-1:0]  ITER_LAST = ITER_W'(ITERS - 1);

  typedef struct packed {
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_x;
  } in_payload_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
  } out_payload_t;

  typedef enum logic [2:0] {
    OP_HOLD = 3'd0,
    OP_LOAD = 3'd1,
    OP_SHR  = 3'd2,
    OP_SHL  = 3'd3,
    OP_ROT  = 3'd4
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ITER_W-1:0] iter;
  } ctrl_t;

  typedef struct packed {
    logic need_shr;
    logic can_shl;
  } status_t;

  // arctan(2^-i) in 1/256 of an angle unit
  function automatic zacc_t atan_entry(input logic [ITER_W-1:0] idx);
    zacc_t v;
    case (idx)
      4'd0:    v = 20'sd131072;
      4'd1:    v = 20'sd77376;
      4'd2:    v = 20'sd40884;
      4'd3:    v = 20'sd20753;
      4'd4:    v = 20'sd10417;
      4'd5:    v = 20'sd5213;
      4'd6:    v = 20'sd2607;
      4'd7:    v = 20'sd1304;
      4'd8:    v = 20'sd652;
      4'd9:    v = 20'sd326;
      4'd10:   v = 20'sd163;
      4'd11:   v = 20'sd81;
      4'd12:   v = 20'sd41;
      4'd13:   v = 20'sd20;
      4'd14:   v = 20'sd10;
      4'd15:   v = 20'sd5;
      default: v = 20'sd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/catan_stream_if.sv */
// valid/ready stream interface with a typed payload
interface catan_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/catan_datapath.sv */
// vector and angle registers with the shared shift/add unit of the cordic
module catan_datapath (
  input  logic                          clk,
  input  catan_pkg::ctrl_t              ctrl,
  input  catan_pkg::in_payload_t        load_data,
  output catan_pkg::status_t            status,
  output logic [catan_pkg::ANGLE_W-1:0] angle
);

  catan_pkg::word_t x;
  catan_pkg::word_t y;
  catan_pkg::zacc_t z;
  logic             half;

  catan_pkg::word_t lx;
  catan_pkg::word_t ly;
  catan_pkg::word_t xs;
  catan_pkg::word_t ys;
  catan_pkg::zacc_t arc;
  logic             y_pos;

  logic [catan_pkg::Z_W-1:0]     z_mag;
  logic [catan_pkg::Z_W-1:0]     z_rnd;
  logic [catan_pkg::ANGLE_W-1:0] r_mag;
  logic [catan_pkg::ANGLE_W-1:0] r_sgn;

  assign lx    = catan_pkg::word_t'(load_data.vec_x);
  assign ly    = catan_pkg::word_t'(load_data.vec_y);
  assign xs    = x >>> ctrl.iter;
  assign ys    = y >>> ctrl.iter;
  assign arc   = catan_pkg::atan_entry(ctrl.iter);
  assign y_pos = (y > catan_pkg::word_t'(0));

  assign status.need_shr = (x > catan_pkg::NORM_HIGH) || (y > catan_pkg::NORM_HIGH) ||
                           (y < -catan_pkg::NORM_HIGH);
  assign status.can_shl  = (x < catan_pkg::NORM_LOW) && (y < catan_pkg::NORM_LOW) &&
                           (y > -catan_pkg::NORM_LOW);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      catan_pkg::OP_LOAD: begin
        if (load_data.vec_x[31]) begin
          x <= -lx;
          y <= -ly;
        end else begin
          x <= lx;
          y <= ly;
        end
        half <= load_data.vec_x[31];
        z    <= '0;
      end
      catan_pkg::OP_SHR: begin
        x <= x >>> 1;
        y <= y >>> 1;
      end
      catan_pkg::OP_SHL: begin
        x <= x <<< 1;
        y <= y <<< 1;
      end
      catan_pkg::OP_ROT: begin
        if (y_pos) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + arc;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - arc;
        end
      end
      default: begin
      end
    endcase
  end

  // round half away from zero, drop the fraction, add the half turn
  assign z_mag = z[catan_pkg::Z_W-1] ? catan_pkg::Z_W'(-z) : catan_pkg::Z_W'(z);
  assign z_rnd = z_mag + catan_pkg::Z_W'(catan_pkg::FRAC_HALF);
  assign r_mag = catan_pkg::ANGLE_W'(z_rnd >> catan_pkg::FRAC_SHIFT);
  assign r_sgn = z[catan_pkg::Z_W-1] ? (catan_pkg::ANGLE_W'(0) - r_mag) : r_mag;
  assign angle = r_sgn + (half ? catan_pkg::HALF_TURN : catan_pkg::ANGLE_W'(0));

endmodule

/* rtl/cordic_atan2_unit.sv */
// top level of the cordic vectoring atan2 unit: sequencer and output register
//
//   channel  dir  payload                     meaning
//   vec      in   vec_y[31:0], vec_x[31:0]    signed vector, two's complement
//   ang      out  angle[11:0]                 angle, 4096 units per turn
//
// one transaction at a time: vec.ready is high only while the sequencer idles
// a transaction loads the vector, does r right shifts (0..11) and l left
// shifts (0..18) of normalisation, one bit per cycle, then 16 rotations
// through the shared shift/add stage; a zero vector skips to the final step
// the result sits in an output register, so a stalled ang holds only the
// final step, and the sequencer waits there until the register frees up
// rst is synchronous and clears the sequencer and the output valid only
module cordic_atan2_unit (
  input logic            clk,
  input logic            rst,
  catan_stream_if.sink   vec,
  catan_stream_if.source ang
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_NORM_R = 5'b00010,
    ST_NORM_L = 5'b00100,
    ST_ROTATE = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t                          state;
  state_t                          state_next;
  logic [catan_pkg::ITER_W-1:0]    iter;
  logic [catan_pkg::ITER_W-1:0]    iter_next;
  logic                            res_valid;
  logic [catan_pkg::ANGLE_W-1:0]   res_angle;

  catan_pkg::ctrl_t                ctrl;
  catan_pkg::status_t              status;
  logic [catan_pkg::ANGLE_W-1:0]   dp_angle;
  logic                            accept;
  logic                            zero_vec;
  logic                            res_load;

  assign vec.ready = (state == ST_IDLE);
  assign accept    = vec.valid && vec.ready;
  assign zero_vec  = (vec.data.vec_y == 32'sd0) && (vec.data.vec_x == 32'sd0);
  // the output register takes the angle once the previous one has gone
  assign res_load  = (state == ST_DONE) && (!res_valid || ang.ready);

  // sequencer: one datapath operation per cycle
  always_comb begin
    state_next = state;
    iter_next  = iter;
    ctrl.op    = catan_pkg::OP_HOLD;
    ctrl.iter  = iter;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          ctrl.op = catan_pkg::OP_LOAD;
          // a zero vector skips normalisation and rotation, z stays at zero
          state_next = zero_vec ? ST_DONE : ST_NORM_R;
        end
      end
      ST_NORM_R: begin
        if (status.need_shr) begin
          ctrl.op = catan_pkg::OP_SHR;
        end else begin
          state_next = ST_NORM_L;
        end
      end
      ST_NORM_L: begin
        if (status.can_shl) begin
          ctrl.op = catan_pkg::OP_SHL;
        end else begin
          state_next = ST_ROTATE;
          iter_next  = '0;
        end
      end
      ST_ROTATE: begin
        ctrl.op   = catan_pkg::OP_ROT;
        iter_next = iter + 1'b1;
        if (iter == catan_pkg::ITER_LAST) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      iter      <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      iter  <= iter_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (ang.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_angle <= dp_angle;
    end
  end

  assign ang.valid      = res_valid;
  assign ang.data.angle = res_angle;

  catan_datapath u_datapath (
    .clk       (clk),
    .ctrl      (ctrl),
    .load_data (vec.data),
    .status    (status),
    .angle     (dp_angle)
  );

  // rotations always start from a fully normalised vector
  a_rot_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_ROTATE) |-> $past(state == ST_NORM_L))
    else $error("rotation entered without normalisation");

  a_iter_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_NORM_L && state_next == ST_ROTATE) |=> (iter == '0))
    else $error("rotation counter not cleared at start");

  // left shifting never pushes the vector past the upper bound
  a_norm_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_NORM_L) |-> !status.need_shr)
    else $error("vector above bound during left normalisation");

  a_res_src: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == ST_DONE))
    else $error("result raised outside the final step");

endmodule

/* bench/testbench.sv */
// self-checking testbench for the cordic atan2 unit with a built-in angle predictor
`timescale 1ns / 100ps

module testbench;

  // generous bound: the slowest run with heavy receiver stalls stays well below this
  localparam int CYCLE_LIMIT   = 1_000_000;
  // covers the longest transaction, so a late result is still seen
  localparam int SETTLE_CYCLES = 64;
  localparam int SWEEP_ITEMS   = 570;

  // normalisation window of the vectoring datapath
  localparam longint SCALE_CEIL  = 64'sd1 << 20;
  localparam longint SCALE_FLOOR = 64'sd1 << 18;

  // arctan(2^-i) in 1/256 of an angle unit
  localparam longint ARC_STEP [catan_pkg::ITERS] = '{
    131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
    652, 326, 163, 81, 41, 20, 10, 5
  };

  logic clk = 1'b0;
  logic rst;
  int   src_idle_pct = 0;
  int   snk_idle_pct = 0;
  int   mismatch_count = 0;
  int   cycle_count = 0;

  // angles owed by the unit, oldest first
  logic [catan_pkg::ANGLE_W-1:0] expected_angles [$];

  catan_stream_if #(.payload_t(catan_pkg::in_payload_t))  vec_bus ();
  catan_stream_if #(.payload_t(catan_pkg::out_payload_t)) ang_bus ();

  cordic_atan2_unit u_dut (
    .clk (clk),
    .rst (rst),
    .vec (vec_bus),
    .ang (ang_bus)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // angle of (vy, vx) as the vectoring cordic computes it, bit for bit
  function automatic logic [catan_pkg::ANGLE_W-1:0] predict_angle(
    input logic signed [31:0] vy,
    input logic signed [31:0] vx
  );
    longint y, x, z, xs, ys, xn, r, half;
    y    = vy;
    x    = vx;
    z    = 0;
    half = 0;
    if (x == 0 && y == 0) begin
      return '0;
    end
    // fold the left half-plane onto the right, remember the half turn
    if (x < 0) begin
      x    = -x;
      y    = -y;
      half = catan_pkg::HALF_TURN;
    end
    // floor shifts down into the window, then doubling up to its lower edge
    while (x > SCALE_CEIL || y > SCALE_CEIL || y < -SCALE_CEIL) begin
      x = x >>> 1;
      y = y >>> 1;
    end
    while (x < SCALE_FLOOR && y < SCALE_FLOOR && y > -SCALE_FLOOR) begin
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < catan_pkg::ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        xn = x + ys;
        y  = y - xs;
        z  = z + ARC_STEP[i];
      end else begin
        xn = x - ys;
        y  = y + xs;
        z  = z - ARC_STEP[i];
      end
      x = xn;
    end
    // round half away from zero to whole angle units
    if (z >= 0) begin
      r = (z + (1 << (catan_pkg::FRAC_SHIFT - 1))) / (1 << catan_pkg::FRAC_SHIFT);
    end else begin
      r = -((-z + (1 << (catan_pkg::FRAC_SHIFT - 1))) / (1 << catan_pkg::FRAC_SHIFT));
    end
    // truncation to the angle width is the wrap modulo a full turn
    return catan_pkg::ANGLE_W'(r + half);
  endfunction

  // full-range words most often, plus narrow, tiny, zero and end-of-range values
  function automatic logic signed [31:0] rand_component();
    logic [31:0] v;
    int          w;
    case ($urandom_range(7))
      0, 1, 2: begin
        v = $urandom;
      end
      3, 4: begin
        w = $urandom_range(1, 31);
        v = $urandom & ((32'd1 << w) - 32'd1);
        if ($urandom_range(1)) begin
          v = -v;
        end
      end
      5: begin
        v = $urandom_range(3);
        if ($urandom_range(1)) begin
          v = -v;
        end
      end
      6: begin
        v = '0;
      end
      default: begin
        v = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      end
    endcase
    return v;
  endfunction

  // offer one vector, with random idle cycles first, and wait for the transaction
  task automatic send_vector(input logic signed [31:0] y, input logic signed [31:0] x);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      vec_bus.valid <= 1'b0;
      @(negedge clk);
    end
    vec_bus.valid <= 1'b1;
    vec_bus.data  <= '{vec_y: y, vec_x: x};
    @(posedge clk);
    while (!vec_bus.ready) begin
      @(posedge clk);
    end
  endtask

  // sender holds off until every owed angle has come back
  task automatic drain_results();
    @(negedge clk);
    vec_bus.valid <= 1'b0;
    while (expected_angles.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // zero vector, the four axes and the four diagonals
  task automatic test_axes_and_zero();
    send_vector(0, 0);
    send_vector(0, 1);
    send_vector(1, 0);
    send_vector(0, -1);
    send_vector(-1, 0);
    send_vector(1, 1);
    send_vector(-1, -1);
    send_vector(1, -1);
    send_vector(-1, 1);
    drain_results();
  endtask

  // most negative and most positive words, where negation must not overflow
  task automatic test_extremes();
    send_vector(32'sh8000_0000, 32'sh8000_0000);
    send_vector(32'sh7fff_ffff, 32'sh7fff_ffff);
    send_vector(32'sh8000_0000, 0);
    send_vector(0, 32'sh8000_0000);
    send_vector(32'sh8000_0000, 32'sh7fff_ffff);
    send_vector(32'sh7fff_ffff, 32'sh8000_0000);
    send_vector(1, 32'sh8000_0000);
    drain_results();
  endtask

  // window edges, floor shift of a small negative y, long doubling, wrap near zero
  task automatic test_normalisation();
    send_vector(-1, 32'sh7fff_ffff);
    send_vector(3, 5);
    send_vector(1, 262143);
    send_vector(0, 1048577);
    send_vector(-1048577, 1048576);
    send_vector(-3, 1000);
    send_vector(-1, -32'sh7fff_ffff);
    drain_results();
  endtask

  // random vectors under one idling profile, ending with a full drain
  task automatic test_random_sweep(input int count, input int src_pct, input int snk_pct);
    logic signed [31:0] y, x;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int n = 0; n < count; n++) begin
      y = rand_component();
      x = rand_component();
      // diagonals now and then
      if ($urandom_range(7) == 0) begin
        y = $urandom_range(1) ? x : -x;
      end
      send_vector(y, x);
    end
    drain_results();
  endtask

  // receiver readiness, redrawn every cycle
  always @(negedge clk) begin
    ang_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // result check first, then the prediction for any vector accepted at this edge
  always @(posedge clk) begin : scoreboard
    logic [catan_pkg::ANGLE_W-1:0] want;
    if (!rst) begin
      if (ang_bus.valid && ang_bus.ready) begin
        if (expected_angles.size() == 0) begin
          $error("angle: transaction with nothing owed, actual %0d", ang_bus.data.angle);
          mismatch_count++;
        end else begin
          want = expected_angles.pop_front();
          if (ang_bus.data.angle !== want) begin
            $error("angle mismatch: expected %0d, actual %0d", want, ang_bus.data.angle);
            mismatch_count++;
          end
        end
      end
      if (vec_bus.valid && vec_bus.ready) begin
        expected_angles.push_back(predict_angle(vec_bus.data.vec_y, vec_bus.data.vec_x));
      end
    end
  end

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    vec_bus.valid = 1'b0;
    vec_bus.data  = '0;
    ang_bus.ready = 1'b0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    test_axes_and_zero();
    test_extremes();
    test_normalisation();
    // sender mostly busy with a sluggish receiver, then the reverse, then full rate
    test_random_sweep(SWEEP_ITEMS, 11, 84);
    test_random_sweep(SWEEP_ITEMS, 84, 11);
    test_random_sweep(SWEEP_ITEMS, 0, 0);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/catan_pkg.sv
rtl/catan_stream_if.sv
rtl/catan_datapath.sv
rtl/cordic_atan2_unit.sv
bench/testbench.sv
